@@ hdl/cdclk_pkg.sv @@
// Shared types and constants for the countdown clock with hold.
`default_nettype none

package cdclk_pkg;

    localparam int TIME_WIDTH = 48;
    localparam int FIELD_WIDTH = 48;
    localparam int NOW_WIDTH = 32;
    localparam int OP_WIDTH = 3;
    localparam int IN_DATA_WIDTH = 80;
    localparam int OUT_DATA_WIDTH = 104;

    typedef logic signed [TIME_WIDTH-1:0] time_t;
    typedef logic signed [FIELD_WIDTH-1:0] field_t;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_READ        = 3'd0,
        OP_START       = 3'd1,
        OP_STOP        = 3'd2,
        OP_SET_HOLD    = 3'd3,
        OP_RELEASE     = 3'd4,
        OP_SET_CLOCK   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_AT_HOLD     = 2'd1,
        ST_HOLD_PASSED = 2'd2
    } status_t;

    typedef struct packed {
        time_t zero_ref;
        time_t stop_inst;
        logic  halted;
        time_t hold_val;
        logic  hold;
    } clk_state_t;

    typedef struct packed {
        field_t  hold_point;
        logic    hold_active;
        logic    clock_stopped;
        field_t  mission_time;
        status_t status;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/countdown_clock_with_hold_core.sv @@
// Countdown clock with hold: top level with input and result registers.
// Flow: a word accepted into the input register is loaded into the result
// register when the output side can take a word, and is then offered as the result word.
// Throughput: one command word per cycle; the result register and the
// input register advance together whenever the output side can take a word.
// Reset: asynchronous, active low; clock stopped at zero, no hold set,
// both stages empty.
`default_nettype none

module countdown_clock_with_hold_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // now_ms [31:0], argument [79:32]
    input  wire logic [cdclk_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
    // operation [2:0]
    input  wire logic [cdclk_pkg::OP_WIDTH-1:0]         s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // status [1:0], mission_time [49:2], clock_stopped [50],
    // hold_active [51], hold_point [99:52], zero [103:100]
    output logic [cdclk_pkg::OUT_DATA_WIDTH-1:0]        m_tdata
);
    import cdclk_pkg::*;

    logic                  in_valid_reg;
    logic [OP_WIDTH-1:0]   op_reg;
    logic [NOW_WIDTH-1:0]  now_reg;
    field_t                arg_reg;
    logic                  out_valid_reg;
    result_t               res_reg;
    clk_state_t            state_reg;
    clk_state_t            state_next;
    result_t               res_next;
    logic                  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    cdclk_update u_update (
        .cur       (state_reg),
        .operation (op_reg),
        .now_ms    (now_reg),
        .argument  (arg_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.zero_ref <= '0;
            state_reg.stop_inst <= '0;
            state_reg.halted <= 1'b1;
            state_reg.hold_val <= '0;
            state_reg.hold <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= s_tuser;
            now_reg <= s_tdata[NOW_WIDTH-1:0];
            arg_reg <= s_tdata[NOW_WIDTH+FIELD_WIDTH-1:NOW_WIDTH];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(OUT_DATA_WIDTH - $bits(result_t)){1'b0}}, res_reg};

endmodule

`default_nettype wire

@@ hdl/cdclk_update.sv @@
// Next-state and result logic for one command of the countdown clock.
`default_nettype none

module cdclk_update (
    input  wire cdclk_pkg::clk_state_t              cur,
    input  wire logic [cdclk_pkg::OP_WIDTH-1:0]     operation,
    input  wire logic [cdclk_pkg::NOW_WIDTH-1:0]    now_ms,
    input  wire logic signed [cdclk_pkg::FIELD_WIDTH-1:0] argument,
    output cdclk_pkg::clk_state_t                   nxt,
    output cdclk_pkg::result_t                      res
);
    import cdclk_pkg::*;

    time_t now_t;
    time_t arg_t;
    time_t hold_at;
    time_t resumed_ref;
    time_t ref_t;
    time_t new_ref;
    time_t new_hold_at;
    time_t mt;
    logic  reached;
    status_t status;

    assign now_t = time_t'(now_ms);
    assign arg_t = time_t'(argument);
    assign hold_at = cur.zero_ref + cur.hold_val;
    assign resumed_ref = now_t + (cur.zero_ref - cur.stop_inst);

    always_comb
    begin
        nxt = cur;
        status = ST_OK;
        ref_t = cur.halted ? resumed_ref : cur.zero_ref;
        new_ref = now_t - cur.hold_val;
        reached = 1'b0;
        unique case (op_t'(operation))
            OP_START:
            begin
                if (cur.halted)
                begin
                    nxt.halted = 1'b0;
                    nxt.zero_ref = resumed_ref;
                    if (cur.hold && (now_t > resumed_ref + cur.hold_val))
                    begin
                        nxt.hold = 1'b0;
                    end
                end
            end
            OP_STOP:
            begin
                if (!cur.halted)
                begin
                    nxt.stop_inst = now_t;
                    nxt.halted = 1'b1;
                    if (cur.hold && (now_t >= hold_at))
                    begin
                        nxt.zero_ref = new_ref;
                    end
                end
            end
            OP_SET_HOLD:
            begin
                if (!cur.halted && cur.hold && (now_t > hold_at))
                begin
                    status = ST_AT_HOLD;
                end
                else if (now_t > ref_t + arg_t)
                begin
                    status = ST_HOLD_PASSED;
                end
                else
                begin
                    nxt.hold_val = arg_t;
                    nxt.hold = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (cur.hold)
                begin
                    nxt.hold = 1'b0;
                    if (now_t >= hold_at)
                    begin
                        nxt.zero_ref = new_ref;
                        if (cur.halted)
                        begin
                            nxt.stop_inst = cur.stop_inst + (new_ref - cur.zero_ref);
                        end
                    end
                end
            end
            OP_SET_CLOCK:
            begin
                nxt.zero_ref = now_t - arg_t;
                if (cur.halted)
                begin
                    nxt.stop_inst = now_t;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        new_hold_at = nxt.zero_ref + nxt.hold_val;
        reached = nxt.hold && (now_t > new_hold_at);
        if (nxt.halted)
        begin
            mt = nxt.stop_inst - nxt.zero_ref;
        end
        else if (reached)
        begin
            mt = nxt.hold_val;
        end
        else
        begin
            mt = now_t - nxt.zero_ref;
        end

        res.status = status;
        res.mission_time = field_t'(mt);
        res.clock_stopped = nxt.halted;
        res.hold_active = nxt.hold;
        res.hold_point = nxt.hold ? field_t'(nxt.hold_val) : '0;
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the countdown clock with hold: directed and random command streams.
`timescale 1ns / 1ps

module tb_top;
    import cdclk_pkg::*;

    typedef struct {
        logic [OP_WIDTH-1:0] op;
        logic [NOW_WIDTH-1:0] now_ms;
        time_t arg;
        bit drain;
    } cmd_word_t;

    localparam time_t T_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam time_t T_MIN = 48'sh8000_0000_0000;
    localparam int RANDOM_WORDS = 1600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_WIDTH-1:0] s_tdata = '0;
    logic [OP_WIDTH-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;

    cmd_word_t cmd_pending[$];
    result_t readings_due[$];
    clk_state_t plan_clk;
    clk_state_t live_clk;
    int word_total = 0;
    int accepted_cnt = 0;
    int mismatches = 0;
    int cyc = 0;
    bit word_taken = 1'b0;

    countdown_clock_with_hold_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic clk_state_t clock_at_reset();
        clk_state_t s;
        s.zero_ref = '0;
        s.stop_inst = '0;
        s.halted = 1'b1;
        s.hold_val = '0;
        s.hold = 1'b0;
        return s;
    endfunction

    function automatic result_t clock_advance(inout clk_state_t s,
                                              input logic [OP_WIDTH-1:0] op,
                                              input logic [NOW_WIDTH-1:0] now_ms,
                                              input time_t arg);
        time_t zref, sinst, hval, t_now, base, reach, old_ref, mt;
        logic halted, hflag, blocked;
        status_t st;
        result_t r;
        zref = s.zero_ref;
        sinst = s.stop_inst;
        hval = s.hold_val;
        halted = s.halted;
        hflag = s.hold;
        t_now = time_t'({16'h0, now_ms});
        st = ST_OK;
        blocked = 1'b0;
        case (op)
            OP_START:
            begin
                if (halted)
                begin
                    halted = 1'b0;
                    zref = t_now + (zref - sinst);
                    reach = zref + hval;
                    if (hflag && t_now > reach)
                        hflag = 1'b0;
                end
            end
            OP_STOP:
            begin
                if (!halted)
                begin
                    sinst = t_now;
                    halted = 1'b1;
                    reach = zref + hval;
                    if (hflag && t_now >= reach)
                        zref = sinst - hval;
                end
            end
            OP_SET_HOLD:
            begin
                base = zref;
                if (halted)
                    base = t_now + (zref - sinst);
                else
                begin
                    reach = zref + hval;
                    if (hflag && t_now > reach)
                    begin
                        st = ST_AT_HOLD;
                        blocked = 1'b1;
                    end
                end
                if (!blocked)
                begin
                    reach = base + arg;
                    if (t_now > reach)
                        st = ST_HOLD_PASSED;
                    else
                    begin
                        hval = arg;
                        hflag = 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (hflag)
                begin
                    hflag = 1'b0;
                    reach = zref + hval;
                    if (t_now >= reach)
                    begin
                        old_ref = zref;
                        zref = t_now - hval;
                        if (halted)
                            sinst = sinst + (zref - old_ref);
                    end
                end
            end
            OP_SET_CLOCK:
            begin
                zref = t_now - arg;
                if (halted)
                    sinst = t_now;
            end
            default:
            begin
            end
        endcase
        if (halted)
            mt = sinst - zref;
        else
        begin
            reach = zref + hval;
            if (hflag && t_now > reach)
                mt = hval;
            else
                mt = t_now - zref;
        end
        s.zero_ref = zref;
        s.stop_inst = sinst;
        s.hold_val = hval;
        s.halted = halted;
        s.hold = hflag;
        r.status = st;
        r.mission_time = mt;
        r.clock_stopped = halted;
        r.hold_active = hflag;
        r.hold_point = hflag ? hval : '0;
        return r;
    endfunction

    task automatic add_word(input logic [OP_WIDTH-1:0] op, input logic [NOW_WIDTH-1:0] t,
                            input time_t a, input bit drain);
        cmd_word_t w;
        result_t unused;
        w.op = op;
        w.now_ms = t;
        w.arg = a;
        w.drain = drain;
        unused = clock_advance(plan_clk, op, t, a);
        cmd_pending.push_back(w);
        word_total++;
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", field, want, got);
    endtask

    // driver: present words at the falling edge, hold until taken
    always @(negedge clk)
    begin
        cmd_word_t w;
        bit calm;
        cyc++;
        calm = (cyc >= 2000) && (cyc < 3500);
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || word_taken)
        begin
            word_taken = 1'b0;
            if (cmd_pending.size() != 0 && (calm || $urandom_range(99) >= 34)
                && !(cmd_pending[0].drain && readings_due.size() != 0))
            begin
                w = cmd_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {w.arg, w.now_ms};
                s_tuser <= w.op;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= calm || ($urandom_range(99) >= 34);
    end

    // monitor: check result words, then record accepted command words
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (readings_due.size() == 0)
                    note_mismatch("unexpected word", '0, 64'(m_tdata[63:0]));
                else
                begin
                    want = readings_due.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        note_mismatch("status", 64'(want.status), 64'(m_tdata[1:0]));
                    if (m_tdata[49:2] !== want.mission_time)
                        note_mismatch("mission_time", 64'(want.mission_time),
                                      64'(m_tdata[49:2]));
                    if (m_tdata[50] !== want.clock_stopped)
                        note_mismatch("clock_stopped", 64'(want.clock_stopped),
                                      64'(m_tdata[50]));
                    if (m_tdata[51] !== want.hold_active)
                        note_mismatch("hold_active", 64'(want.hold_active),
                                      64'(m_tdata[51]));
                    if (m_tdata[99:52] !== want.hold_point)
                        note_mismatch("hold_point", 64'(want.hold_point),
                                      64'(m_tdata[99:52]));
                    if (m_tdata[103:100] !== 4'h0)
                        note_mismatch("pad", '0, 64'(m_tdata[103:100]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                readings_due.push_back(clock_advance(live_clk, s_tuser, s_tdata[31:0],
                                                     s_tdata[79:32]));
                word_taken = 1'b1;
                accepted_cnt++;
            end
        end
    end

    initial
    begin
        logic [NOW_WIDTH-1:0] wall;
        logic [63:0] rnd;
        logic [OP_WIDTH-1:0] op;
        time_t arg;
        time_t mt;
        clk_state_t probe;
        result_t peek;
        int k;
        plan_clk = clock_at_reset();
        live_clk = clock_at_reset();

        add_word(OP_READ, 32'd0, '0, 1'b0);
        add_word(3'd6, 32'd10, T_MAX, 1'b0);
        add_word(3'd7, 32'd20, T_MIN, 1'b0);
        add_word(OP_SET_HOLD, 32'd100, -48'sd1, 1'b0);
        add_word(OP_SET_HOLD, 32'd100, 48'sd50, 1'b0);
        add_word(OP_SET_HOLD, 32'd110, 48'sd60, 1'b0);
        add_word(OP_START, 32'd1000, '0, 1'b0);
        add_word(OP_START, 32'd1010, '0, 1'b0);
        add_word(OP_READ, 32'd1100, '0, 1'b0);
        add_word(OP_SET_HOLD, 32'd1100, 48'sd200, 1'b0);
        add_word(OP_STOP, 32'd1200, '0, 1'b0);
        add_word(OP_STOP, 32'd1300, '0, 1'b0);
        add_word(OP_RELEASE, 32'd1300, '0, 1'b0);
        add_word(OP_RELEASE, 32'd1310, '0, 1'b0);
        add_word(OP_SET_HOLD, 32'd1400, 48'sd100, 1'b0);
        add_word(OP_START, 32'd1500, '0, 1'b0);
        add_word(OP_READ, 32'd1600, '0, 1'b0);
        add_word(OP_RELEASE, 32'd1600, '0, 1'b0);
        add_word(OP_SET_HOLD, 32'd1700, 48'sd500, 1'b0);
        add_word(OP_STOP, 32'd1800, '0, 1'b0);
        add_word(OP_SET_CLOCK, 32'd1900, 48'sd1000, 1'b0);
        add_word(OP_START, 32'd2000, '0, 1'b0);
        add_word(OP_SET_CLOCK, 32'hFFFF_FFFF, T_MAX, 1'b0);
        add_word(OP_READ, 32'd0, '0, 1'b0);
        add_word(OP_SET_CLOCK, 32'd0, T_MIN, 1'b0);
        add_word(OP_SET_HOLD, 32'd5, T_MAX, 1'b0);
        add_word(OP_SET_HOLD, 32'd6, T_MIN, 1'b0);
        add_word(OP_STOP, 32'hFFFF_FFFF, '0, 1'b0);

        wall = 32'd5000;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            k = $urandom_range(99);
            if (k < 4)
                wall = $urandom;
            else if (k < 6)
                wall = 32'hFFFF_FFFF - $urandom_range(0, 20);
            else if (k < 8)
                wall = $urandom_range(0, 20);
            else
                wall = wall + $urandom_range(0, 40);

            k = $urandom_range(99);
            if (k < 18)
                op = OP_READ;
            else if (k < 32)
                op = OP_START;
            else if (k < 46)
                op = OP_STOP;
            else if (k < 66)
                op = OP_SET_HOLD;
            else if (k < 80)
                op = OP_RELEASE;
            else if (k < 94)
                op = OP_SET_CLOCK;
            else if (k < 97)
                op = 3'd6;
            else
                op = 3'd7;

            probe = plan_clk;
            peek = clock_advance(probe, OP_READ, wall, '0);
            mt = peek.mission_time;
            rnd = {$urandom, $urandom};
            k = $urandom_range(99);
            if (k < 8)
                arg = rnd[47:0];
            else if (k < 10)
                arg = rnd[0] ? T_MAX : T_MIN;
            else if (op == OP_SET_HOLD)
                arg = mt + time_t'($urandom_range(0, 120)) - time_t'(30);
            else
                arg = time_t'($urandom_range(0, 3000)) - time_t'(1500);

            add_word(op, wall, arg, (i % 400) == 0);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != word_total)
            @(posedge clk);
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
